@@ sv/dswa_pkg.sv @@
// ----------------------------------------------------------------------------
// Disjoint-set engine package
// Item types, command codes, microcode word format and control program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dswa_pkg;

  localparam int MAX_MEMBERS_DEF = 64;
  localparam int MEMBER_W        = 6;
  localparam int CMD_W           = 2;
  localparam int PC_W            = 5;

  localparam logic [CMD_W-1:0] CMD_LINK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADJ      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAME     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [MEMBER_W-1:0] member_a;
    logic [MEMBER_W-1:0] member_b;
  } in_item_t;

  typedef struct packed {
    logic             answer;
    logic [CMD_W-1:0] done_kind;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADJ_RD_A,
    OP_ADJ_WRA_RDB,
    OP_ADJ_WR_B,
    OP_ADJ_CHK,
    OP_FA_INIT,
    OP_FIND_RD,
    OP_FIND_HALVE,
    OP_FB_INIT,
    OP_SAVE_R2,
    OP_SIZE_B,
    OP_UNION,
    OP_SAME,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_BAD,
    C_CMD_ADJ,
    C_CMD_SAME,
    C_ROOT,
    C_SAME_ROOT,
    C_END
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] S_ENTRY    = PC_W'(0);
  localparam logic [PC_W-1:0] S_DISP_ADJ = PC_W'(1);
  localparam logic [PC_W-1:0] S_DISP_SAM = PC_W'(2);
  localparam logic [PC_W-1:0] S_LNK_RD   = PC_W'(3);
  localparam logic [PC_W-1:0] S_LNK_WRA  = PC_W'(4);
  localparam logic [PC_W-1:0] S_LNK_WRB  = PC_W'(5);
  localparam logic [PC_W-1:0] S_FA_INIT  = PC_W'(6);
  localparam logic [PC_W-1:0] S_FA_CHK   = PC_W'(7);
  localparam logic [PC_W-1:0] S_FA_HALVE = PC_W'(8);
  localparam logic [PC_W-1:0] S_FB_INIT  = PC_W'(9);
  localparam logic [PC_W-1:0] S_FB_CHK   = PC_W'(10);
  localparam logic [PC_W-1:0] S_FB_HALVE = PC_W'(11);
  localparam logic [PC_W-1:0] S_SAVE_R2  = PC_W'(12);
  localparam logic [PC_W-1:0] S_SIZE_B   = PC_W'(13);
  localparam logic [PC_W-1:0] S_UNION    = PC_W'(14);
  localparam logic [PC_W-1:0] S_QADJ_RD  = PC_W'(15);
  localparam logic [PC_W-1:0] S_QADJ_CHK = PC_W'(16);
  localparam logic [PC_W-1:0] S_SAME     = PC_W'(17);
  localparam logic [PC_W-1:0] S_FIN      = PC_W'(18);
  localparam logic [PC_W-1:0] PROG_LEN   = PC_W'(19);

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      S_ENTRY:    w = '{OP_NOP,         C_BAD,       S_FIN};
      S_DISP_ADJ: w = '{OP_NOP,         C_CMD_ADJ,   S_QADJ_RD};
      S_DISP_SAM: w = '{OP_NOP,         C_CMD_SAME,  S_FA_INIT};
      S_LNK_RD:   w = '{OP_ADJ_RD_A,    C_NEXT,      S_ENTRY};
      S_LNK_WRA:  w = '{OP_ADJ_WRA_RDB, C_NEXT,      S_ENTRY};
      S_LNK_WRB:  w = '{OP_ADJ_WR_B,    C_NEXT,      S_ENTRY};
      S_FA_INIT:  w = '{OP_FA_INIT,     C_NEXT,      S_ENTRY};
      S_FA_CHK:   w = '{OP_FIND_RD,     C_ROOT,      S_FB_INIT};
      S_FA_HALVE: w = '{OP_FIND_HALVE,  C_ALWAYS,    S_FA_CHK};
      S_FB_INIT:  w = '{OP_FB_INIT,     C_NEXT,      S_ENTRY};
      S_FB_CHK:   w = '{OP_FIND_RD,     C_ROOT,      S_SAVE_R2};
      S_FB_HALVE: w = '{OP_FIND_HALVE,  C_ALWAYS,    S_FB_CHK};
      S_SAVE_R2:  w = '{OP_SAVE_R2,     C_CMD_SAME,  S_SAME};
      S_SIZE_B:   w = '{OP_SIZE_B,      C_SAME_ROOT, S_FIN};
      S_UNION:    w = '{OP_UNION,       C_ALWAYS,    S_FIN};
      S_QADJ_RD:  w = '{OP_ADJ_RD_A,    C_NEXT,      S_ENTRY};
      S_QADJ_CHK: w = '{OP_ADJ_CHK,     C_ALWAYS,    S_FIN};
      S_SAME:     w = '{OP_SAME,        C_NEXT,      S_ENTRY};
      S_FIN:      w = '{OP_FINISH,      C_END,       S_ENTRY};
      default:    w = '{OP_FINISH,      C_END,       S_ENTRY};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/disjoint_set_with_adjacency_top.sv @@
// ----------------------------------------------------------------------------
// Disjoint-set engine with adjacency matrix
// Union by size with path halving, plus a direct-adjacency bit matrix.
// ----------------------------------------------------------------------------
// One item at a time: busy rises on the cycle after start is taken and falls
// with the result strobe. A same-set query or a link takes longer for each
// parent hop walked, and a link does a union step when the two roots differ.
// The hop cost comes from the single read port of the parent memory: each
// path-halving hop is one read to test and one read-and-write to halve. The
// result is shown for exactly one cycle and cannot be held off. After reset,
// busy stays high while the parent, size and adjacency memories are
// initialised one entry per cycle. Members at or above MAX_MEMBERS and the
// reserved command leave state alone and answer 0.
`timescale 1ns / 1ps
`default_nettype none

module disjoint_set_with_adjacency_top #(
  parameter int MAX_MEMBERS = dswa_pkg::MAX_MEMBERS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  dswa_pkg::in_item_t  in_item,
  output logic                out_valid,
  output dswa_pkg::out_item_t out_item
);

  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int SZ_W  = $clog2(MAX_MEMBERS + 1);
  localparam int CMP_W = ((IDX_W > dswa_pkg::MEMBER_W) ? IDX_W : dswa_pkg::MEMBER_W) + 1;
  localparam int PC_W  = dswa_pkg::PC_W;

  logic [IDX_W-1:0]       par_mem [MAX_MEMBERS];
  logic [SZ_W-1:0]        size_mem [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] adj_mem [MAX_MEMBERS];

  logic                   clr_r;
  logic [IDX_W-1:0]       clr_idx_r;
  logic                   run_r, run_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  dswa_pkg::out_item_t    out_item_r, out_item_nxt;

  logic [dswa_pkg::CMD_W-1:0]    cmd_r;
  logic [dswa_pkg::MEMBER_W-1:0] a_r, b_r;
  logic [IDX_W-1:0]       m_r, m_nxt;
  logic [IDX_W-1:0]       r1_r, r1_nxt;
  logic [IDX_W-1:0]       r2_r, r2_nxt;
  logic [SZ_W-1:0]        s1_r, s1_nxt;
  logic                   ans_r, ans_nxt;

  logic [IDX_W-1:0]       prd_r;
  logic [SZ_W-1:0]        srd_r;
  logic [MAX_MEMBERS-1:0] arow_r;

  logic                   pw_en, sw_en, aw_en;
  logic [IDX_W-1:0]       pw_addr, pw_data, pr_addr;
  logic [IDX_W-1:0]       sw_addr, sr_addr;
  logic [SZ_W-1:0]        sw_data, size_sum;
  logic [IDX_W-1:0]       aw_addr, ar_addr;
  logic [MAX_MEMBERS-1:0] aw_data, bit_a, bit_b;

  logic                   accept, bad, take;
  logic [IDX_W-1:0]       a_idx, b_idx;
  dswa_pkg::uword_t       uw;

  assign accept   = start && !busy;
  assign busy     = run_r || clr_r;
  assign a_idx    = IDX_W'(a_r);
  assign b_idx    = IDX_W'(b_r);
  assign bit_a    = {{(MAX_MEMBERS-1){1'b0}}, 1'b1} << a_idx;
  assign bit_b    = {{(MAX_MEMBERS-1){1'b0}}, 1'b1} << b_idx;
  assign size_sum = SZ_W'(s1_r + srd_r);
  assign bad      = (CMP_W'(a_r) >= CMP_W'(MAX_MEMBERS)) ||
                    (CMP_W'(b_r) >= CMP_W'(MAX_MEMBERS)) ||
                    (cmd_r == dswa_pkg::CMD_RESERVED);
  assign uw       = dswa_pkg::ucode(pc_r);

  always_comb begin
    case (uw.cond)
      dswa_pkg::C_ALWAYS:    take = 1'b1;
      dswa_pkg::C_BAD:       take = bad;
      dswa_pkg::C_CMD_ADJ:   take = (cmd_r == dswa_pkg::CMD_ADJ);
      dswa_pkg::C_CMD_SAME:  take = (cmd_r == dswa_pkg::CMD_SAME);
      dswa_pkg::C_ROOT:      take = (prd_r == m_r);
      dswa_pkg::C_SAME_ROOT: take = (r1_r == r2_r);
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    pw_en   = 1'b0;
    pw_addr = m_r;
    pw_data = prd_r;
    pr_addr = prd_r;
    sw_en   = 1'b0;
    sw_addr = r1_r;
    sw_data = size_sum;
    sr_addr = r1_r;
    aw_en   = 1'b0;
    aw_addr = a_idx;
    aw_data = arow_r | bit_b;
    ar_addr = a_idx;

    m_nxt         = m_r;
    r1_nxt        = r1_r;
    r2_nxt        = r2_r;
    s1_nxt        = s1_r;
    ans_nxt       = ans_r;
    run_nxt       = run_r;
    pc_nxt        = pc_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    if (clr_r) begin
      pw_en   = 1'b1;
      pw_addr = clr_idx_r;
      pw_data = clr_idx_r;
      sw_en   = 1'b1;
      sw_addr = clr_idx_r;
      sw_data = SZ_W'(1);
      aw_en   = 1'b1;
      aw_addr = clr_idx_r;
      aw_data = '0;
    end else if (run_r) begin
      case (uw.op)
        dswa_pkg::OP_ADJ_RD_A: begin
          ar_addr = a_idx;
        end
        dswa_pkg::OP_ADJ_WRA_RDB: begin
          aw_en   = 1'b1;
          aw_addr = a_idx;
          aw_data = arow_r | bit_b;
          ar_addr = b_idx;
        end
        dswa_pkg::OP_ADJ_WR_B: begin
          aw_en   = 1'b1;
          aw_addr = b_idx;
          aw_data = arow_r | bit_a;
        end
        dswa_pkg::OP_ADJ_CHK: begin
          ans_nxt = arow_r[b_idx];
        end
        dswa_pkg::OP_FA_INIT: begin
          m_nxt   = a_idx;
          pr_addr = a_idx;
        end
        dswa_pkg::OP_FIND_RD: begin
          pr_addr = prd_r;
        end
        dswa_pkg::OP_FIND_HALVE: begin
          pw_en   = 1'b1;
          pw_addr = m_r;
          pw_data = prd_r;
          m_nxt   = prd_r;
          pr_addr = prd_r;
        end
        dswa_pkg::OP_FB_INIT: begin
          r1_nxt  = m_r;
          m_nxt   = b_idx;
          pr_addr = b_idx;
        end
        dswa_pkg::OP_SAVE_R2: begin
          r2_nxt  = m_r;
          sr_addr = r1_r;
        end
        dswa_pkg::OP_SIZE_B: begin
          s1_nxt  = srd_r;
          sr_addr = r2_r;
        end
        dswa_pkg::OP_UNION: begin
          pw_en = 1'b1;
          sw_en = 1'b1;
          if (s1_r < srd_r) begin
            pw_addr = r1_r;
            pw_data = r2_r;
            sw_addr = r2_r;
          end else begin
            pw_addr = r2_r;
            pw_data = r1_r;
            sw_addr = r1_r;
          end
        end
        dswa_pkg::OP_SAME: begin
          ans_nxt = (r1_r == r2_r);
        end
        dswa_pkg::OP_FINISH: begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.answer    = ans_r;
          out_item_nxt.done_kind = cmd_r;
        end
        default: begin
        end
      endcase

      if (uw.cond == dswa_pkg::C_END) begin
        run_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end else if (accept) begin
      run_nxt = 1'b1;
      pc_nxt  = dswa_pkg::S_ENTRY;
      ans_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      run_r       <= 1'b0;
      pc_r        <= dswa_pkg::S_ENTRY;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        if (clr_idx_r == IDX_W'(MAX_MEMBERS - 1)) begin
          clr_r <= 1'b0;
        end
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      run_r       <= run_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !run_r) begin
      cmd_r <= in_item.command;
      a_r   <= in_item.member_a;
      b_r   <= in_item.member_b;
    end
    m_r        <= m_nxt;
    r1_r       <= r1_nxt;
    r2_r       <= r2_nxt;
    s1_r       <= s1_nxt;
    ans_r      <= ans_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      par_mem[pw_addr] <= pw_data;
    end
    prd_r <= par_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      size_mem[sw_addr] <= sw_data;
    end
    srd_r <= size_mem[sr_addr];
  end

  always_ff @(posedge clk) begin
    if (aw_en) begin
      adj_mem[aw_addr] <= aw_data;
    end
    arow_r <= adj_mem[ar_addr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_strobe_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(run_r) && !run_r))
    else $error("result strobe without a finishing program");

  a_no_run_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_r && run_r))
    else $error("program running during memory initialisation");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (pc_r < dswa_pkg::PROG_LEN))
    else $error("step counter outside the control program");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result strobe for an item");

  a_halve_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && uw.op == dswa_pkg::OP_FIND_HALVE) |-> (prd_r != m_r))
    else $error("path halving would write a parent onto itself");

endmodule

`default_nettype wire

@@ bench/dswa_checker.sv @@
// ----------------------------------------------------------------------------
// Disjoint-set engine checker
// Watches the command and result channels and keeps its own copy of the
// parent links, set sizes and adjacency matrix. It works out the answer for
// every accepted item and compares each strobed result, in order, with the
// oldest answer still outstanding. It reports mismatches and outstanding
// answers to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dswa_checker #(
  parameter int MEMBERS = dswa_pkg::MAX_MEMBERS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 busy,
  input  dswa_pkg::in_item_t  in_item,
  input  wire                 out_valid,
  input  dswa_pkg::out_item_t out_item,
  output int unsigned         mismatches,
  output int unsigned         pending_items
);

  localparam int MW = dswa_pkg::MEMBER_W;

  logic [MW-1:0]       up_link  [MEMBERS];
  logic [6:0]          grp_size [MEMBERS];
  logic [MEMBERS-1:0]  adj_bits [MEMBERS];
  dswa_pkg::out_item_t answers_due [$];
  int unsigned         fail_tally = 0;

  initial begin
    mismatches    = 0;
    pending_items = 0;
  end

  // halve the path on the way up
  function automatic logic [MW-1:0] find_root(input logic [MW-1:0] m);
    logic [MW-1:0] cur;
    cur = m;
    while (up_link[cur] != cur) begin
      up_link[cur] = up_link[up_link[cur]];
      cur = up_link[cur];
    end
    return cur;
  endfunction

  function automatic dswa_pkg::out_item_t resolve_command(input dswa_pkg::in_item_t it);
    dswa_pkg::out_item_t res;
    logic [MW-1:0]       ra;
    logic [MW-1:0]       rb;
    res.answer    = 1'b0;
    res.done_kind = it.command;
    if (int'(it.member_a) < MEMBERS && int'(it.member_b) < MEMBERS) begin
      case (it.command)
        dswa_pkg::CMD_LINK: begin
          adj_bits[it.member_a][it.member_b] = 1'b1;
          adj_bits[it.member_b][it.member_a] = 1'b1;
          ra = find_root(it.member_a);
          rb = find_root(it.member_b);
          if (ra != rb) begin
            if (grp_size[ra] < grp_size[rb]) begin
              up_link[ra]  = rb;
              grp_size[rb] = grp_size[rb] + grp_size[ra];
            end else begin
              up_link[rb]  = ra;
              grp_size[ra] = grp_size[ra] + grp_size[rb];
            end
          end
        end
        dswa_pkg::CMD_ADJ: begin
          res.answer = adj_bits[it.member_a][it.member_b];
        end
        dswa_pkg::CMD_SAME: begin
          ra = find_root(it.member_a);
          rb = find_root(it.member_b);
          res.answer = (ra == rb);
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    dswa_pkg::out_item_t due;
    if (!rst_n) begin
      for (int i = 0; i < MEMBERS; i++) begin
        up_link[i]  = MW'(i);
        grp_size[i] = 7'd1;
        adj_bits[i] = '0;
      end
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: answer %0d done_kind %0d",
                 out_item.answer, out_item.done_kind);
          fail_tally = fail_tally + 1;
        end else begin
          due = answers_due.pop_front();
          if (out_item.answer !== due.answer) begin
            $error("answer: expected %0d, got %0d", due.answer, out_item.answer);
            fail_tally = fail_tally + 1;
          end
          if (out_item.done_kind !== due.done_kind) begin
            $error("done_kind: expected %0d, got %0d", due.done_kind, out_item.done_kind);
            fail_tally = fail_tally + 1;
          end
        end
      end
      if (start && !busy) begin
        answers_due.push_back(resolve_command(in_item));
      end
    end
    mismatches    <= fail_tally;
    pending_items <= answers_due.size();
  end

endmodule

@@ bench/tb_disjoint_set_with_adjacency_top.sv @@
// ----------------------------------------------------------------------------
// Disjoint-set engine testbench
// Drives a short directed run of links and queries, covering self links,
// links inside one set, equal-size unions, the reserved command and the
// member extremes. It follows with random commands drawn from shifting
// windows of members so that sets grow deep. Sender gaps come in random
// bursts, and the checker beside the block decides each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_disjoint_set_with_adjacency_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 530;
  localparam int CALM_TAIL    = 80;
  localparam int CW           = dswa_pkg::CMD_W;
  localparam int MW           = dswa_pkg::MEMBER_W;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  dswa_pkg::in_item_t  in_item = '0;
  logic                busy;
  logic                out_valid;
  dswa_pkg::out_item_t out_item;
  int unsigned         mismatches;
  int unsigned         pending_items;
  int unsigned         cycle_count = 0;
  bit                  gaps_on = 1'b1;
  dswa_pkg::in_item_t  linked_pairs [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  disjoint_set_with_adjacency_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  dswa_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .mismatches    (mismatches),
    .pending_items (pending_items)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_command(input logic [CW-1:0] cmd,
                              input logic [MW-1:0] a,
                              input logic [MW-1:0] b);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{command: cmd, member_a: a, member_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [CW-1:0] cmd;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
    logic [MW-1:0] win_base;
    int unsigned   win_span;
    int unsigned   roll;
    int unsigned   pick;
    win_base = '0;
    win_span = 64;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_command(dswa_pkg::CMD_ADJ, 6'd0, 6'd63);
    push_command(dswa_pkg::CMD_SAME, 6'd0, 6'd63);
    push_command(dswa_pkg::CMD_SAME, 6'd5, 6'd5);
    push_command(dswa_pkg::CMD_ADJ, 6'd7, 6'd7);
    push_command(dswa_pkg::CMD_LINK, 6'd7, 6'd7);
    push_command(dswa_pkg::CMD_ADJ, 6'd7, 6'd7);
    push_command(dswa_pkg::CMD_LINK, 6'd0, 6'd63);
    push_command(dswa_pkg::CMD_ADJ, 6'd63, 6'd0);
    push_command(dswa_pkg::CMD_SAME, 6'd63, 6'd0);
    push_command(dswa_pkg::CMD_LINK, 6'd63, 6'd0);
    push_command(dswa_pkg::CMD_RESERVED, 6'd63, 6'd0);
    push_command(dswa_pkg::CMD_RESERVED, 6'd0, 6'd63);
    push_command(dswa_pkg::CMD_LINK, 6'd1, 6'd2);
    push_command(dswa_pkg::CMD_LINK, 6'd3, 6'd4);
    push_command(dswa_pkg::CMD_LINK, 6'd1, 6'd3);
    push_command(dswa_pkg::CMD_SAME, 6'd2, 6'd4);
    push_command(dswa_pkg::CMD_ADJ, 6'd2, 6'd4);
    push_command(dswa_pkg::CMD_LINK, 6'd0, 6'd4);
    push_command(dswa_pkg::CMD_SAME, 6'd63, 6'd2);
    push_command(dswa_pkg::CMD_LINK, 6'd62, 6'd61);
    push_command(dswa_pkg::CMD_SAME, 6'd62, 6'd7);
    push_command(dswa_pkg::CMD_ADJ, 6'd61, 6'd62);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        win_base = MW'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
          0:       win_span = 4;
          1:       win_span = 8;
          2:       win_span = 16;
          default: win_span = 64;
        endcase
      end
      gaps_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 40) % 3 != 2);
      a    = win_base + MW'($urandom_range(0, win_span - 1));
      b    = win_base + MW'($urandom_range(0, win_span - 1));
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        cmd = dswa_pkg::CMD_LINK;
        linked_pairs.push_back('{command: dswa_pkg::CMD_LINK, member_a: a, member_b: b});
      end else if (roll < 52 && linked_pairs.size() != 0) begin
        cmd  = dswa_pkg::CMD_ADJ;
        pick = $urandom_range(0, linked_pairs.size() - 1);
        a    = linked_pairs[pick].member_a;
        b    = linked_pairs[pick].member_b;
        if ($urandom_range(0, 1) == 1) begin
          a = linked_pairs[pick].member_b;
          b = linked_pairs[pick].member_a;
        end
      end else if (roll < 70) begin
        cmd = dswa_pkg::CMD_ADJ;
      end else if (roll < 96) begin
        cmd = dswa_pkg::CMD_SAME;
      end else begin
        cmd = dswa_pkg::CMD_RESERVED;
      end
      push_command(cmd, a, b);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_items != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && pending_items == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
